// File: design/dvc_pkg.sv
// ----------------------------------------------------------------------------
// dvc_pkg: shared types and constants of the delta varint column codec
// Holds the queue entry between front and back, register indexes and the
// LEB128 group constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dvc_pkg;

    localparam int unsigned MAX_VALUE_W = 64;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned GROUP_BITS  = 7;
    localparam int unsigned SHIFT_W     = 7;   // holds 0..64
    localparam int unsigned CFG_IDX_W   = 1;

    // queue between front and back
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;
    localparam int unsigned QCNT_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_BASE = 1'b1;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [GROUP_BITS-1:0] GROUP_MASK = 7'h7F;

    typedef struct packed {
        logic                   dec;       // entry is a decoded value
        logic                   overflow;
        logic [MAX_VALUE_W-1:0] value;     // delta-coded value or decoded result
    } t_entry;

endpackage

`default_nettype wire

// File: design/dvc_in_if.sv
// ----------------------------------------------------------------------------
// dvc_in_if: input channel of the codec
// valid/ready handshake carrying one value or one coded byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dvc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] in_value;
    logic [7:0]  in_byte;
    logic        column_start;

    modport source (output valid, in_value, in_byte, column_start, input ready);
    modport sink   (input valid, in_value, in_byte, column_start, output ready);
endinterface

`default_nettype wire

// File: design/dvc_out_if.sv
// ----------------------------------------------------------------------------
// dvc_out_if: result channel of the codec
// valid/ready handshake carrying one coded byte or one decoded value per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dvc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [63:0] out_value;
    logic        last;
    logic        overflow;

    modport source (output valid, out_byte, out_value, last, overflow, input ready);
    modport sink   (input valid, out_byte, out_value, last, overflow, output ready);
endinterface

`default_nettype wire

// File: design/dvc_front.sv
// ----------------------------------------------------------------------------
// dvc_front: accept side of the codec
// Applies the delta on encode, collects varint bytes on decode, and queues
// one entry per value for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dvc_front #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_direction,
    input  wire logic [dvc_pkg::MAX_VALUE_W-1:0]   i_delta_base,
    dvc_in_if.sink                                 i_in,
    input  wire logic                              i_full,
    output logic                                   o_push,
    output dvc_pkg::t_entry                        o_entry
);
    import dvc_pkg::*;

    localparam logic [MAX_VALUE_W-1:0] MASK = {MAX_VALUE_W{1'b1}} >> (MAX_VALUE_W - VALUE_WIDTH);
    localparam logic [SHIFT_W-1:0]     VW_SC = SHIFT_W'(VALUE_WIDTH);
    localparam int unsigned            SH_W  = MAX_VALUE_W + 8;

    logic [MAX_VALUE_W-1:0] r_acc, n_acc;
    logic [SHIFT_W-1:0]     r_sc,  n_sc;
    logic                   r_ovf, n_ovf;
    logic                   r_fvp;

    logic                   accept;
    logic                   fvp_eff;
    logic [MAX_VALUE_W-1:0] base_m, v_in, enc_val, dec_val;
    logic [MAX_VALUE_W-1:0] acc_b;
    logic [SHIFT_W-1:0]     sc_b;
    logic                   ovf_b;
    logic [GROUP_BITS-1:0]  payload;
    logic [SH_W-1:0]        sh;
    logic [SHIFT_W:0]       sc_sum;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        base_m  = i_delta_base & MASK;
        v_in    = i_in.in_value & MASK;
        fvp_eff = i_in.column_start | r_fvp;
        enc_val = fvp_eff ? v_in : ((v_in - base_m) & MASK);

        // column start drops any partial varint
        acc_b   = i_in.column_start ? '0 : r_acc;
        sc_b    = i_in.column_start ? '0 : r_sc;
        ovf_b   = i_in.column_start ? 1'b0 : r_ovf;
        payload = i_in.in_byte[GROUP_BITS-1:0];
        sh      = SH_W'(payload) << sc_b;
        sc_sum  = {1'b0, sc_b} + (SHIFT_W+1)'(GROUP_BITS);

        if (sc_b < VW_SC) begin
            n_acc = (acc_b | sh[MAX_VALUE_W-1:0]) & MASK;
            n_ovf = ovf_b | (|(sh >> VALUE_WIDTH));
            n_sc  = (sc_sum > {1'b0, VW_SC}) ? VW_SC : sc_sum[SHIFT_W-1:0];
        end else begin
            n_acc = acc_b;
            n_sc  = sc_b;
            n_ovf = ovf_b | (|payload);
        end
        dec_val = fvp_eff ? n_acc : ((n_acc + base_m) & MASK);

        o_push = accept && ((i_direction == DIR_ENCODE) || !i_in.in_byte[BYTE_W-1]);
        if (i_direction == DIR_ENCODE) begin
            o_entry = '{dec: 1'b0, overflow: 1'b0, value: enc_val};
        end else begin
            o_entry = '{dec: 1'b1, overflow: n_ovf, value: dec_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sc  <= '0;
            r_ovf <= 1'b0;
            r_fvp <= 1'b1;
        end else if (accept) begin
            if (i_direction == DIR_ENCODE) begin
                r_fvp <= 1'b0;
            end else if (i_in.in_byte[BYTE_W-1]) begin
                r_acc <= n_acc;
                r_sc  <= n_sc;
                r_ovf <= n_ovf;
                r_fvp <= fvp_eff;
            end else begin
                r_acc <= '0;
                r_sc  <= '0;
                r_ovf <= 1'b0;
                r_fvp <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/dvc_queue.sv
// ----------------------------------------------------------------------------
// dvc_queue: two-entry queue between front and back
// Lets the accept side and the emit side stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module dvc_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire dvc_pkg::t_entry  i_entry,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output dvc_pkg::t_entry       o_head
);
    import dvc_pkg::*;

    localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QDEPTH);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/dvc_back.sv
// ----------------------------------------------------------------------------
// dvc_back: emit side of the codec
// Splits a queued value into LEB128 bytes, one per cycle unless stalled, or
// passes a decoded value through; drives the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module dvc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_head_valid,
    input  wire dvc_pkg::t_entry  i_head,
    output logic                  o_pop,
    dvc_out_if.source             o_out
);
    import dvc_pkg::*;

    logic                   r_busy;
    logic [MAX_VALUE_W-1:0] r_work;
    logic                   r_valid;
    logic [BYTE_W-1:0]      r_byte;
    logic [MAX_VALUE_W-1:0] r_value;
    logic                   r_last;
    logic                   r_ovf;

    logic                   slot_free, emit;
    logic [MAX_VALUE_W-1:0] src, rem;
    logic                   src_dec;

    assign slot_free = !r_valid || o_out.ready;
    assign emit      = slot_free && (r_busy || i_head_valid);
    assign o_pop     = slot_free && !r_busy && i_head_valid;
    assign src       = r_busy ? r_work : i_head.value;
    assign src_dec   = !r_busy && i_head.dec;
    assign rem       = src >> GROUP_BITS;

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.out_value = r_value;
    assign o_out.last      = r_last;
    assign o_out.overflow  = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else if (slot_free) begin
            r_valid <= emit;
            if (emit) begin
                if (src_dec) begin
                    r_busy <= 1'b0;
                end else begin
                    r_busy <= (rem != '0);
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_work <= rem;
            if (src_dec) begin
                r_byte  <= '0;
                r_value <= src;
                r_last  <= 1'b1;
                r_ovf   <= i_head.overflow;
            end else begin
                r_byte  <= {(rem != '0), src[GROUP_BITS-1:0] & GROUP_MASK};
                r_value <= '0;
                r_last  <= (rem == '0);
                r_ovf   <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/delta_varint_column_codec.sv
// ----------------------------------------------------------------------------
// delta_varint_column_codec: delta + unsigned LEB128 integer column codec
// Encodes values into 1..ceil(VALUE_WIDTH/7) bytes or decodes bytes back to
// values, with a configurable delta base per column.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat carries                                   handshake
//  i_in      in   in_value, in_byte, column_start                valid/ready
//  o_out     out  out_byte, out_value, last, overflow            valid/ready
//  i_cfg_*   in   register index, 64-bit data                    write enable
//
//  Front takes one beat a cycle while the two-entry queue has room.
//  Encode: the back end emits one byte a cycle unless o_out stalls, and a
//  value takes ceil(width of the delta / 7) bytes, 1 to ceil(VALUE_WIDTH/7).
//  Decode: one coded byte a cycle in, one value out per final byte.
//  Reset (synchronous, active low) clears registers to encode / base 0,
//  empties the queue and marks the next value as a column's first.
//  A stalled result holds in the output register; the queue absorbs two
//  further values before i_in.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_varint_column_codec #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    dvc_in_if.sink                                   i_in,
    dvc_out_if.source                                o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [dvc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [dvc_pkg::MAX_VALUE_W-1:0]     i_cfg_wdata
);
    import dvc_pkg::*;

    // configuration registers; user ensures they are written only while idle
    logic                   r_direction;
    logic [MAX_VALUE_W-1:0] r_delta_base;

    logic   push, full, pop, head_valid;
    t_entry entry, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= DIR_ENCODE;
            r_delta_base <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIRECTION:  r_direction  <= i_cfg_wdata[0];
                CFG_DELTA_BASE: r_delta_base <= i_cfg_wdata;
                default:        r_direction  <= r_direction;
            endcase
        end
    end

    // front: delta and varint collection, one beat a cycle unless queue full
    dvc_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_direction  (r_direction),
        .i_delta_base (r_delta_base),
        .i_in         (i_in),
        .i_full       (full),
        .o_push       (push),
        .o_entry      (entry)
    );

    dvc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // back: byte splitter and result register
    dvc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

// File: dv/delta_varint_column_codec_tb.sv
// ----------------------------------------------------------------------------
// delta_varint_column_codec_tb: self-checking bench for the varint column codec
// A directed table covers field extremes, column starts, long and overflowing
// varints and mode switches with live state. Random phases then follow, one
// for each direction / delta base pair. Every output beat is checked against
// an in-bench model of the delta + LEB128 behaviour or a typed table result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module delta_varint_column_codec_tb;

    import dvc_pkg::*;

    localparam int SETTLE     = 8;    // cycles for the pipe to drain before a register write
    localparam int TAIL       = 16;   // quiet cycles after the last expected beat
    localparam int PHASE_BEATS = 50;  // input beats per random phase
    localparam int PHASE_VALS = 12;   // min results per random phase

    // one input beat and one output beat
    typedef struct packed {
        logic [63:0] value;
        logic [7:0]  code_byte;
        logic        col_start;
    } t_beat;

    typedef struct packed {
        logic [7:0]  code_byte;
        logic [63:0] value;
        logic        last;
        logic        ovf;
    } t_codec_out;

    // directed table
    typedef enum logic [0:0] {ROW_CFG, ROW_BEAT} t_row_kind;
    // EXP_MODEL: model decides; EXP_NONE: no result; EXP_ONE: single typed result
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} t_exp_mode;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [63:0]           word;      // register data or value to encode
        logic [7:0]            code_byte;
        logic                  col_start;
        t_exp_mode             mode;
        t_codec_out            want;
    } t_row;

    localparam t_codec_out NO_OUT = '0;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int N_DIRECTED = 33;

    // Directed stimulus. Typed results only where obvious: zero, single-group
    // values, base wrap to one, a two-byte decode and the all-ones overflowing varint.
    t_row dir_tab [N_DIRECTED] = '{
        // encode, base 0
        '{ROW_CFG,  CFG_DIRECTION,  64'(DIR_ENCODE), 8'h00, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_CFG,  CFG_DELTA_BASE, 64'd0,           8'h00, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'h00, 1'b1, EXP_ONE,
          '{8'h00, 64'd0, 1'b1, 1'b0}},
        '{ROW_BEAT, CFG_DIRECTION,  64'd127,         8'h00, 1'b0, EXP_ONE,
          '{8'h7F, 64'd0, 1'b1, 1'b0}},
        '{ROW_BEAT, CFG_DIRECTION,  64'd128,         8'h00, 1'b0, EXP_MODEL, NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  ALL_ONES,        8'h00, 1'b0, EXP_MODEL, NO_OUT},
        // encode, base all ones: 0 - base wraps to 1
        '{ROW_CFG,  CFG_DELTA_BASE, ALL_ONES,        8'h00, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'h00, 1'b0, EXP_ONE,
          '{8'h01, 64'd0, 1'b1, 1'b0}},
        '{ROW_BEAT, CFG_DIRECTION,  ALL_ONES,        8'h00, 1'b1, EXP_MODEL, NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  ALL_ONES - 64'd1, 8'h00, 1'b0, EXP_MODEL, NO_OUT},
        // decode
        '{ROW_CFG,  CFG_DIRECTION,  64'(DIR_DECODE), 8'h00, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_CFG,  CFG_DELTA_BASE, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, EXP_NONE, NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'h00, 1'b1, EXP_ONE,
          '{8'h00, 64'd0, 1'b1, 1'b0}},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'h85, 1'b0, EXP_NONE,  NO_OUT},
        // column start mid-varint drops the 0x85 partial
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'h81, 1'b1, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'h01, 1'b0, EXP_ONE,
          '{8'h00, 64'h81, 1'b1, 1'b0}},
        // long varint: 63 one bits, bit 63, a silent zero group, then excess bits
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'hFF, 1'b1, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'hFF, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'hFF, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'hFF, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'hFF, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'hFF, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'hFF, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'hFF, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'hFF, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'h81, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'h80, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'h02, 1'b0, EXP_ONE,
          '{8'h00, ALL_ONES, 1'b1, 1'b1}},
        // leave a partial varint, encode one value, then finish the varint
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'h83, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_CFG,  CFG_DIRECTION,  64'(DIR_ENCODE), 8'h00, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd5,           8'h00, 1'b0, EXP_MODEL, NO_OUT},
        '{ROW_CFG,  CFG_DIRECTION,  64'(DIR_DECODE), 8'h00, 1'b0, EXP_NONE,  NO_OUT},
        '{ROW_BEAT, CFG_DIRECTION,  64'd0,           8'h00, 1'b0, EXP_MODEL, NO_OUT}
    };

    // ------------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [MAX_VALUE_W-1:0] i_cfg_wdata;
    logic sink_ready = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    dvc_in_if  in_if ();
    dvc_out_if out_if ();

    assign out_if.ready = sink_ready;

    delta_varint_column_codec #(.VALUE_WIDTH(64)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Codec model: mirrors registers and decode state. Both modes share the
    // first-value flag; encoding leaves the decode accumulator alone.
    // ------------------------------------------------------------------------
    logic        mdl_dir;
    logic [63:0] mdl_base;
    logic [63:0] acc_word;
    int          acc_shift;
    logic        acc_ovf;
    logic        first_pending;

    t_codec_out  step_out[$];        // beats caused by the last accepted input
    t_codec_out  codec_out_due[$];   // beats owed by the DUT, oldest first

    int errors       = 0;
    int beats_sent   = 0;
    int results_owed = 0;
    int bytes_seen   = 0;
    int values_seen  = 0;
    int ovf_seen     = 0;
    int burst_left   = 0;

    task automatic delta_leb128_step(input t_beat b);
        logic [63:0] d;
        logic [7:0]  grp;
        logic [6:0]  pay;
        int          n;
        int          room;
        t_codec_out  res;
        step_out.delete();
        if (mdl_dir == DIR_ENCODE) begin
            if (b.col_start)
                first_pending = 1'b1;
            d = b.value;
            if (!first_pending)
                d = d - mdl_base;
            first_pending = 1'b0;
            n = 0;
            // low group first, continuation bit on all but the final byte
            do begin
                grp = {1'b0, d[6:0]};
                d   = d >> 7;
                if (d != 0)
                    grp[7] = 1'b1;
                res = '{grp, 64'd0, (d == 0), 1'b0};
                step_out.insert(step_out.size(), res);
                n++;
            end while (d != 0 && n < 10);
        end else begin
            if (b.col_start) begin
                acc_word      = '0;
                acc_shift     = 0;
                acc_ovf       = 1'b0;
                first_pending = 1'b1;
            end
            pay = b.code_byte[6:0];
            if (acc_shift < 64) begin
                room = 64 - acc_shift;
                if (room < 7 && (pay >> room) != 0)
                    acc_ovf = 1'b1;
                acc_word  = acc_word | (64'(pay) << acc_shift);
                acc_shift = (acc_shift + 7 > 64) ? 64 : acc_shift + 7;
            end else if (pay != 0) begin
                acc_ovf = 1'b1;   // payload past bit 63
            end
            if (!b.code_byte[7]) begin
                d = acc_word;
                if (!first_pending)
                    d = d + mdl_base;
                first_pending = 1'b0;
                res = '{8'h00, d, 1'b1, acc_ovf};
                step_out.insert(step_out.size(), res);
                acc_word  = '0;
                acc_shift = 0;
                acc_ovf   = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them. Valid stays
    // high across back-to-back beats within a burst.
    // ------------------------------------------------------------------------
    task automatic drive_beat(input t_beat b, input t_exp_mode mode, input t_codec_out typed);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_if.valid        = 1'b1;
        in_if.in_value     = b.value;
        in_if.in_byte      = b.code_byte;
        in_if.column_start = b.col_start;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        delta_leb128_step(b);
        case (mode)
            EXP_MODEL: begin
                foreach (step_out[i])
                    codec_out_due.insert(codec_out_due.size(), step_out[i]);
                results_owed += step_out.size();
            end
            EXP_ONE: begin
                codec_out_due.insert(codec_out_due.size(), typed);
                results_owed++;
            end
            default: ;
        endcase
        burst_left--;
        beats_sent++;
        @(negedge i_clk);
    endtask

    // register writes only with the DUT drained; trailing partial bytes
    // produce no beat, so also wait out the settle time before the write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        in_if.valid = 1'b0;
        while (codec_out_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_DIRECTION)
            mdl_dir = data[0];
        else
            mdl_base = data;
    endtask

    // random word of random significant width, sometimes an extreme or close
    // to the given point (keeps encode deltas short under a nonzero base)
    function automatic logic [63:0] rand_word(input logic [63:0] near);
        logic [63:0] r;
        int          w;
        r = {$urandom, $urandom};
        w = $urandom_range(0, 64);
        if (w < 64)
            r = r & ((64'd1 << w) - 64'd1);
        case ($urandom_range(0, 15))
            0: r = '0;
            1: r = ALL_ONES;
            2, 3, 4, 5, 6: r = near + r;
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: ready pattern switches between always-on, 1-in-2 and
    // 3-in-4 stretches of random length.
    // ------------------------------------------------------------------------
    int stall_left = 0;
    int stall_mode = 0;

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0: sink_ready <= 1'b1;
            1: sink_ready <= $urandom_range(0, 1);
            default: sink_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Output checker: every accepted beat against the oldest owed beat
    // ------------------------------------------------------------------------
    t_codec_out got;
    t_codec_out want;

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.out_byte, out_if.out_value, out_if.last, out_if.overflow};
            if (codec_out_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat byte %02h value %016h last %0b ovf %0b",
                         $time, got.code_byte, got.value, got.last, got.ovf);
            end else begin
                want = codec_out_due.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch exp byte %02h value %016h last %0b ovf %0b",
                             $time, want.code_byte, want.value, want.last, want.ovf);
                    $display("%0t:          got byte %02h value %016h last %0b ovf %0b",
                             $time, got.code_byte, got.value, got.last, got.ovf);
                end
            end
            if (got.value != 0 || got.ovf || (got.code_byte == 0 && mdl_dir == DIR_DECODE))
                values_seen++;
            else
                bytes_seen++;
            if (got.ovf)
                ovf_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_beat       run[$];
        t_beat       nb;
        logic [63:0] word;
        logic [63:0] base_pick;
        logic [7:0]  grp;
        logic        force_cs;
        int          kind;
        int          start_beats;
        int          start_owed;
        int          directed_beats;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_DIRECTION;
        i_cfg_wdata        = '0;
        in_if.valid        = 1'b0;
        in_if.in_value     = '0;
        in_if.in_byte      = '0;
        in_if.column_start = 1'b0;
        force_cs           = 1'b0;

        // model reset state
        mdl_dir       = DIR_ENCODE;
        mdl_base      = '0;
        acc_word      = '0;
        acc_shift     = 0;
        acc_ovf       = 1'b0;
        first_pending = 1'b1;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG)
                cfg_write(dir_tab[i].reg_idx, dir_tab[i].word);
            else
                drive_beat('{dir_tab[i].word, dir_tab[i].code_byte, dir_tab[i].col_start},
                           dir_tab[i].mode, dir_tab[i].want);
        end
        directed_beats = beats_sent;

        // random phases: each direction against base 0, all ones, random, small
        for (int p = 0; p < 8; p++) begin
            case (p / 2)
                0: base_pick = '0;
                1: base_pick = ALL_ONES;
                2: base_pick = {$urandom, $urandom};
                default: base_pick = 64'($urandom_range(1, 255));
            endcase
            cfg_write(CFG_DIRECTION, (p % 2) ? 64'(DIR_DECODE) : 64'(DIR_ENCODE));
            cfg_write(CFG_DELTA_BASE, base_pick);
            start_beats = beats_sent;
            start_owed  = results_owed;
            while (beats_sent - start_beats < PHASE_BEATS
                   || results_owed - start_owed < PHASE_VALS) begin
                if (mdl_dir == DIR_ENCODE) begin
                    nb = '{rand_word(mdl_base), 8'($urandom), ($urandom_range(0, 9) == 0)};
                    drive_beat(nb, EXP_MODEL, NO_OUT);
                end else begin
                    run.delete();
                    kind = $urandom_range(0, 19);
                    if (kind < 14) begin
                        // well-formed varint, sometimes padded with zero groups
                        word = rand_word(64'd0);
                        do begin
                            grp  = {1'b0, word[6:0]};
                            word = word >> 7;
                            if (word != 0)
                                grp[7] = 1'b1;
                            nb = '{{$urandom, $urandom}, grp, 1'b0};
                            run.insert(run.size(), nb);
                        end while (word != 0);
                        if ($urandom_range(0, 7) == 0) begin
                            run[run.size() - 1].code_byte[7] = 1'b1;
                            repeat ($urandom_range(1, 4)) begin
                                nb = '{{$urandom, $urandom}, 8'h80, 1'b0};
                                run.insert(run.size(), nb);
                            end
                            nb = '{{$urandom, $urandom}, 8'h00, 1'b0};
                            run.insert(run.size(), nb);
                        end
                        run[0].col_start = force_cs || ($urandom_range(0, 4) == 0);
                        force_cs = 1'b0;
                    end else if (kind < 16) begin
                        // ten groups, random top payload: overflow or not
                        repeat (9) begin
                            nb = '{{$urandom, $urandom},
                                   8'h80 | 8'($urandom_range(0, 127)), 1'b0};
                            run.insert(run.size(), nb);
                        end
                        nb = '{{$urandom, $urandom}, 8'($urandom_range(0, 127)), 1'b0};
                        run.insert(run.size(), nb);
                        run[0].col_start = $urandom_range(0, 1);
                    end else if (kind < 18) begin
                        // truncated varint; the next well-formed varint gets a column start
                        repeat ($urandom_range(1, 4)) begin
                            nb = '{{$urandom, $urandom},
                                   8'h80 | 8'($urandom_range(0, 127)), 1'b0};
                            run.insert(run.size(), nb);
                        end
                        force_cs = 1'b1;
                    end else begin
                        // raw noise
                        repeat ($urandom_range(1, 6)) begin
                            nb = '{{$urandom, $urandom}, 8'($urandom),
                                   ($urandom_range(0, 7) == 0)};
                            run.insert(run.size(), nb);
                        end
                    end
                    foreach (run[i])
                        drive_beat(run[i], EXP_MODEL, NO_OUT);
                end
            end
        end

        // drain
        in_if.valid = 1'b0;
        while (codec_out_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL) @(negedge i_clk);

        $display("run: %0d input beats (%0d directed) over 8 direction/base phases",
                 beats_sent, directed_beats);
        $display("run: %0d coded bytes and %0d decoded values checked, %0d with overflow",
                 bytes_seen, values_seen, ovf_seen);
        if (errors == 0)
            $display("delta_varint_column_codec_tb: done, clean");
        else
            $display("delta_varint_column_codec_tb: done, errors");
        $finish;
    end

    // hard stop: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d beats still owed", codec_out_due.size());
        $display("delta_varint_column_codec_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
design/dvc_pkg.sv
design/dvc_in_if.sv
design/dvc_out_if.sv
design/dvc_front.sv
design/dvc_queue.sv
design/dvc_back.sv
design/delta_varint_column_codec.sv
dv/delta_varint_column_codec_tb.sv
